[rtl/core/bmbp_pkg.sv]
// ----------------------------------------------------------------------------
// bmbp_pkg
// shared types and constants of the binary mask boundary point unit
// ----------------------------------------------------------------------------
package bmbp_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  // configuration registers
  localparam int unsigned REG_W    = 7;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // result beat
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned FIFO_DEPTH  = 8;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               eoi;
  } result_t;

  // control broadcast to every column cell
  typedef struct packed {
    logic advance;   // pixel accepted, row continues
    logic row_end;   // pixel accepted, last of its row
    logic img_end;   // pixel accepted, last of the image
    logic solid;     // incoming pixel value
  } cell_ctrl_t;

endpackage

[rtl/core/bmbp_cell.sv]
// ----------------------------------------------------------------------------
// bmbp_cell
// one column cell: row bits, two shifting read taps and the column token
// ----------------------------------------------------------------------------
module bmbp_cell import bmbp_pkg::*; #(
  parameter bit HEAD = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       token_i,
  input  logic       r0_i,
  input  logic       r1_i,
  output logic       token_o,
  output logic       r0_o,
  output logic       r1_o
);

  logic token_q, cur_q, prev_q, r0_q, r1_q;
  logic cur_new;

  // incoming pixel lands in the cell that holds the token
  assign cur_new = token_q ? ctrl_i.solid : cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= HEAD;
      cur_q   <= 1'b0;
      prev_q  <= 1'b0;
      r0_q    <= 1'b0;
      r1_q    <= 1'b0;
    end else if (ctrl_i.img_end) begin
      token_q <= HEAD;
      cur_q   <= 1'b0;
      prev_q  <= 1'b0;
      r0_q    <= 1'b0;
      r1_q    <= 1'b0;
    end else if (ctrl_i.row_end) begin
      token_q <= HEAD;
      cur_q   <= 1'b0;
      prev_q  <= cur_new;
      r0_q    <= cur_new;
      r1_q    <= prev_q;
    end else if (ctrl_i.advance) begin
      token_q <= token_i;
      cur_q   <= cur_new;
      r0_q    <= r0_i;
      r1_q    <= r1_i;
    end
  end

  assign token_o = token_q;
  assign r0_o    = r0_q;
  assign r1_o    = r1_q;

endmodule

[rtl/core/bmbp_result_fifo.sv]
// ----------------------------------------------------------------------------
// bmbp_result_fifo
// result queue, takes up to three beats per cycle, hands out one
// ----------------------------------------------------------------------------
module bmbp_result_fifo import bmbp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    push_cnt_i,
  input  result_t [MAX_RESULTS-1:0]     push_data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output result_t                       data_o,
  output logic                          space_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  result_t        mem_q [FIFO_DEPTH];
  logic [AW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]    count_q, count_d;
  logic           pop;

  assign pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push_cnt_i) begin
        mem_q[wptr_q + AW'(k)] <= push_data_i[k];
      end
    end
  end

  always_comb begin
    wptr_d  = wptr_q + AW'(push_cnt_i);
    rptr_d  = rptr_q + AW'(pop);
    count_d = count_q + (AW+1)'(push_cnt_i) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign space_o = (count_q <= (AW+1)'(FIFO_DEPTH - MAX_RESULTS));

endmodule

[rtl/core/binary_mask_boundary_points_unit.sv]
// ----------------------------------------------------------------------------
// binary_mask_boundary_points_unit
// 8-neighbor boundary point extraction over a streamed binary mask
// ----------------------------------------------------------------------------
// The unit takes one mask pixel per clock in raster order and emits the
// boundary points as row/column beats, followed by one end-of-image beat after
// the last pixel. Border pixels come out right away; an interior pixel comes out
// when its lower-right neighbor arrives, so the output order is not strictly
// row-major. A pixel is accepted every cycle as long as the result queue (eight
// beats) has room for three more; results leave at one beat per clock, so the
// sustained input rate is one pixel per clock unless the mask produces more
// than one point per pixel or the sink stalls. The beats of a pixel are written
// into the result queue when that pixel is taken. Row storage is a chain of
// MAX_WIDTH column cells, so no clearing pass is needed after reset or between
// images. The user must write width and height via the config port only while
// idle; not enforced by the block. 0 acts as 1; values above the maximum clamp.
// ----------------------------------------------------------------------------
module binary_mask_boundary_points_unit import bmbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  // pixel beats
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 pixel_solid_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [COORD_W-1:0]   point_row_o,
  output logic [COORD_W-1:0]   point_col_o,
  output logic                 end_of_image_o
);

  localparam int unsigned CW      = $clog2(MAX_WIDTH);
  localparam int unsigned RW      = $clog2(MAX_HEIGHT);
  localparam int unsigned CNT_MAX = (CW > RW) ? CW : RW;
  // compare width: holds any counter, register or limit with room to spare
  localparam int unsigned DW      = ((CNT_MAX > REG_W) ? CNT_MAX : REG_W) + 1;

  // config registers
  logic [REG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective dimensions, clamped into 1..MAX
  logic [DW-1:0] w_ext, h_ext, w_eff, h_eff, w_last, h_last;

  always_comb begin
    w_ext = DW'(width_q);
    h_ext = DW'(height_q);
    if (w_ext == '0) begin
      w_eff = DW'(1);
    end else if (w_ext > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = DW'(1);
    end else if (h_ext > DW'(MAX_HEIGHT)) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    w_last = w_eff - DW'(1);
    h_last = h_eff - DW'(1);
  end

  // position counters
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [DW-1:0] c_ext, r_ext, c_m1, r_m1;
  logic          accept, last_col, last_row;
  logic          fifo_space;

  assign in_ready_o = fifo_space;
  assign accept     = in_valid_i && in_ready_o;
  assign c_ext      = DW'(col_q);
  assign r_ext      = DW'(row_q);
  assign c_m1       = c_ext - DW'(1);
  assign r_m1       = r_ext - DW'(1);
  // a counter beyond the last position (dimension shrunk mid-image) ends it
  assign last_col   = (c_ext >= w_last);
  assign last_row   = (r_ext >= h_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // column cell chain: tokens move toward the tail, read taps toward the head
  cell_ctrl_t         cell_ctrl;
  logic [MAX_WIDTH:0] tok_chain, r0_chain, r1_chain;

  always_comb begin
    cell_ctrl.advance = accept && !last_col;
    cell_ctrl.row_end = accept && last_col && !last_row;
    cell_ctrl.img_end = accept && last_col && last_row;
    cell_ctrl.solid   = pixel_solid_i;
  end

  assign tok_chain[0]        = 1'b0;
  assign r0_chain[MAX_WIDTH] = 1'b0;
  assign r1_chain[MAX_WIDTH] = 1'b0;

  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_cell
    bmbp_cell #(
      .HEAD (1'(j == 0))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .token_i (tok_chain[j]),
      .r0_i    (r0_chain[j+1]),
      .r1_i    (r1_chain[j+1]),
      .token_o (tok_chain[j+1]),
      .r0_o    (r0_chain[j]),
      .r1_o    (r1_chain[j])
    );
  end

  // head taps: row above and two above at the current column
  logic head_p0, head_p1;
  assign head_p0 = r0_chain[0];
  assign head_p1 = r1_chain[0];

  // 3x3 window history, index 0 is column c-1, index 1 is column c-2
  logic [1:0] win_p0_q, win_p1_q, win_cu_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_p0_q <= {win_p0_q[0], head_p0};
      win_p1_q <= {win_p1_q[0], head_p1};
      win_cu_q <= {win_cu_q[0], pixel_solid_i};
    end
  end

  // judge the interior candidate one row up and one column left
  logic all_solid, interior_hit, border_hit, eoi_hit;

  always_comb begin
    all_solid    = (&win_p1_q) && head_p1 && (&win_cu_q) && pixel_solid_i &&
                   win_p0_q[1] && head_p0;
    interior_hit = (r_ext >= DW'(2)) && (c_ext >= DW'(2)) &&
                   (r_ext <= h_last) && (c_ext <= w_last) &&
                   win_p0_q[0] && !all_solid;
    border_hit   = pixel_solid_i &&
                   ((row_q == '0) || last_row || (col_q == '0) || last_col);
    eoi_hit      = last_col && last_row;
  end

  // pack the beats of this pixel in order: interior, border, end of image
  result_t                   res_int, res_bdr, res_eoi;
  result_t [MAX_RESULTS-1:0] push_data;
  logic [1:0]                push_cnt;

  always_comb begin
    res_int.row = r_m1[COORD_W-1:0];
    res_int.col = c_m1[COORD_W-1:0];
    res_int.eoi = 1'b0;
    res_bdr.row = r_ext[COORD_W-1:0];
    res_bdr.col = c_ext[COORD_W-1:0];
    res_bdr.eoi = 1'b0;
    res_eoi     = '{row: '0, col: '0, eoi: 1'b1};

    push_data[0] = interior_hit ? res_int : (border_hit ? res_bdr : res_eoi);
    push_data[1] = (interior_hit && border_hit) ? res_bdr : res_eoi;
    push_data[2] = res_eoi;

    push_cnt = accept ? ({1'b0, interior_hit} + {1'b0, border_hit} + {1'b0, eoi_hit})
                      : 2'd0;
  end

  result_t out_data;

  bmbp_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (push_data),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data),
    .space_o     (fifo_space)
  );

  assign point_row_o    = out_data.row;
  assign point_col_o    = out_data.col;
  assign end_of_image_o = out_data.eoi;

endmodule

[rtl/core/bmbp_checker.sv]
// ----------------------------------------------------------------------------
// bmbp_checker
// port-level checks of the boundary point unit, bound to the top level
// ----------------------------------------------------------------------------
module bmbp_checker import bmbp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [COORD_W-1:0]   point_row_o,
  input logic [COORD_W-1:0]   point_col_o,
  input logic                 end_of_image_o
);

  // end beat carries no point
  a_eoi_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_image_o |-> point_row_o == '0 && point_col_o == '0)
    else $error("end beat with nonzero coordinates");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_row_o) &&
      $stable(point_col_o) && $stable(end_of_image_o))
    else $error("result beat changed while stalled");

  // results only appear after a pixel beat
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result beat without a pixel beat");

  // input back-pressure only while results are pending
  a_no_deadlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

endmodule

bind binary_mask_boundary_points_unit bmbp_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .point_row_o    (point_row_o),
  .point_col_o    (point_col_o),
  .end_of_image_o (end_of_image_o)
);
